// ----- hw/rtl/wdf_pkg.sv -----
// Shared widths, constants and outcome codes of the water table depth finder.
package wdf_pkg;

    localparam int THK_W   = 20;
    localparam int HEAD_W  = 32;
    localparam int DEPTH_W = 26;
    localparam int OUTC_W  = 2;

    // Shared multiplier operands and product.
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = THK_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Interpolation divider: denominator is twice the head difference.
    localparam int DEN_W    = HEAD_W + 1;
    localparam int QUO_W    = 23;
    localparam int NUM_W    = 55;
    localparam int QCNT_W   = $clog2(QUO_W);
    localparam int Q_OFF_SH = 21;

    localparam logic [QUO_W-1:0]   Q_OFF     = QUO_W'(1) << Q_OFF_SH;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};

    localparam logic [OUTC_W-1:0] OUTC_CROSSING  = 2'd0;
    localparam logic [OUTC_W-1:0] OUTC_BOTTOM_DRY = 2'd1;
    localparam logic [OUTC_W-1:0] OUTC_SATURATED = 2'd2;
    localparam logic [OUTC_W-1:0] OUTC_OVERFLOW  = 2'd3;

endpackage

// ----- hw/rtl/water_table_depth_finder_unit.sv -----
// Water table depth finder: layer store, upward scan and interpolation sequencer.
//
// Usage: a soil column enters on the input channel one layer per transaction,
// top layer first, as thickness and pressure head in 1/16 mm. The transaction
// with i_last_layer set closes the column; one result transaction (depth and
// outcome) follows on the output channel, none for the other layers.
// Throughput: the input takes one layer per cycle up to the last layer. After the last
// layer the input stays not ready while the sequencer works: for an overflow, a
// dry bottom layer or a single layer it runs the check and the hand-off to the output
// register; otherwise it runs the check, scans upward from the bottom one layer per
// cycle, forms two products on the shared multiplier, starts the divider, takes its
// quotient one bit per cycle, then forms the depth and hands it to the output register;
// each hand-off waits until the output register is free.
// The result goes to an output register, so a stalled receiver holds the
// result while the next column loads; only the following result waits.
// Layers beyond MAX_LAYERS are dropped and the column reports an overflow.
// Reset clears the layer count, the running thickness sum and the output
// valid; the layer memory needs no clearing since only current entries are read.
module water_table_depth_finder_unit import wdf_pkg::*; #(
    parameter int MAX_LAYERS = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [THK_W-1:0]         i_thickness,
    input  logic signed [HEAD_W-1:0] i_pressure_head,
    input  logic                     i_last_layer,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [DEPTH_W-1:0]       o_depth,
    output logic [OUTC_W-1:0]        o_outcome
);

    localparam int AW    = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int CNT_W = $clog2(MAX_LAYERS + 1);
    localparam int SW    = THK_W + $clog2(MAX_LAYERS);
    localparam int FW    = ((SW > DEPTH_W) ? SW : DEPTH_W) + 2;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_MUL1  = 4'd3;
    localparam logic [3:0] S_MUL2  = 4'd4;
    localparam logic [3:0] S_PREP  = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    typedef struct packed {
        logic [THK_W-1:0]         thk;
        logic signed [HEAD_W-1:0] head;
        logic [SW-1:0]            prefix;
    } t_layer;

    t_layer r_mem [MAX_LAYERS];
    t_layer r_rd;

    logic [3:0]          r_state, n_state;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_ovf, n_ovf;
    logic [SW-1:0]       r_sum, n_sum;
    logic [AW-1:0]       r_addr, n_addr;
    t_layer              r_prev, n_prev;
    t_layer              r_cur, n_cur;
    logic [DEN_W-1:0]    r_den, n_den;
    logic [NUM_W-1:0]    r_p1, n_p1;
    logic [PROD_W-1:0]   r_p2, n_p2;
    logic [DEPTH_W-1:0]  r_res_depth, n_res_depth;
    logic [OUTC_W-1:0]   r_res_outc, n_res_outc;
    logic                r_out_valid, n_out_valid;
    logic [DEPTH_W-1:0]  r_out_depth, n_out_depth;
    logic [OUTC_W-1:0]   r_out_outc, n_out_outc;

    logic                in_acc;
    logic                wr_en;
    logic                out_free;
    logic [SW-1:0]       new_prefix;
    t_layer              new_layer;
    logic [CNT_W-1:0]    cnt_m2;
    logic [HEAD_W:0]     head_diff;
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [PROD_W-1:0]   mul_p;
    logic [FW-1:0]       fin_val;
    logic [DEPTH_W-1:0]  fin_depth;
    logic                div_start;
    logic                div_done;
    logic [QUO_W-1:0]    div_quo;
    logic [NUM_W-1:0]    div_num;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign wr_en      = in_acc && (r_cnt < CNT_W'(MAX_LAYERS));
    assign out_free   = !r_out_valid || i_out_ready;
    assign new_prefix = r_sum + SW'(i_thickness);
    assign cnt_m2     = r_cnt - CNT_W'(2);
    assign div_num    = r_p1 - NUM_W'(r_p2);

    always_comb begin
        new_layer.thk    = i_thickness;
        new_layer.head   = i_pressure_head;
        new_layer.prefix = new_prefix;
    end

    // Head difference across the crossing; positive by construction.
    assign head_diff = {r_prev.head[HEAD_W-1], r_prev.head}
                     - {r_cur.head[HEAD_W-1], r_cur.head};

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Depth before clamping: the whole column for a dry bottom layer, else the
    // thickness down to the crossing plus the interpolated term.
    always_comb begin
        if (r_state == S_CHECK) begin
            fin_val = FW'(r_prev.prefix);
        end else begin
            fin_val = FW'(r_cur.prefix) + FW'(div_quo) - FW'(Q_OFF);
        end
        if (fin_val[FW-1]) begin
            fin_depth = '0;
        end else if (fin_val > FW'(DEPTH_MAX)) begin
            fin_depth = DEPTH_MAX;
        end else begin
            fin_depth = fin_val[DEPTH_W-1:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_ovf       = r_ovf;
        n_sum       = r_sum;
        n_addr      = r_addr;
        n_prev      = r_prev;
        n_cur       = r_cur;
        n_den       = r_den;
        n_p1        = r_p1;
        n_p2        = r_p2;
        n_res_depth = r_res_depth;
        n_res_outc  = r_res_outc;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_depth = r_out_depth;
        n_out_outc  = r_out_outc;
        mul_a       = '0;
        mul_b       = '0;
        div_start   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (wr_en) begin
                        n_cnt  = r_cnt + CNT_W'(1);
                        n_sum  = new_prefix;
                        n_prev = new_layer;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last_layer) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (r_ovf) begin
                    n_res_depth = '0;
                    n_res_outc  = OUTC_OVERFLOW;
                    n_state     = S_OUT;
                end else if (r_prev.head[HEAD_W-1]) begin
                    n_res_depth = fin_depth;
                    n_res_outc  = OUTC_BOTTOM_DRY;
                    n_state     = S_OUT;
                end else if (r_cnt == CNT_W'(1)) begin
                    n_res_depth = '0;
                    n_res_outc  = OUTC_SATURATED;
                    n_state     = S_OUT;
                end else begin
                    n_addr  = cnt_m2[AW-1:0];
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // r_rd holds the layer at r_addr, r_prev the one just below it.
                if (r_rd.head[HEAD_W-1] && !r_prev.head[HEAD_W-1]) begin
                    n_cur   = r_rd;
                    n_state = S_MUL1;
                end else begin
                    n_prev = r_rd;
                    if (r_addr == '0) begin
                        n_res_depth = '0;
                        n_res_outc  = OUTC_SATURATED;
                        n_state     = S_OUT;
                    end else begin
                        n_addr = r_addr - AW'(1);
                    end
                end
            end
            S_MUL1: begin
                mul_a   = head_diff[MUL_A_W-1:0];
                mul_b   = MUL_B_W'(r_prev.thk);
                n_p1    = NUM_W'(mul_p);
                n_den   = {head_diff[MUL_A_W-1:0], 1'b0};
                n_state = S_MUL2;
            end
            S_MUL2: begin
                mul_a   = {1'b0, r_prev.head[HEAD_W-2:0]};
                mul_b   = MUL_B_W'(r_cur.thk) + MUL_B_W'(r_prev.thk);
                n_p2    = mul_p;
                // Offset keeps the dividend non-negative for the unsigned divider.
                n_p1    = r_p1 + (NUM_W'(r_den) << Q_OFF_SH);
                n_state = S_PREP;
            end
            S_PREP: begin
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_res_depth = fin_depth;
                n_res_outc  = OUTC_CROSSING;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_depth = r_res_depth;
                    n_out_outc  = r_res_outc;
                    n_cnt       = '0;
                    n_ovf       = 1'b0;
                    n_sum       = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    wdf_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_cnt[AW-1:0]] <= new_layer;
        end
        r_rd <= r_mem[n_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_ovf       <= n_ovf;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_prev      <= n_prev;
        r_cur       <= n_cur;
        r_den       <= n_den;
        r_p1        <= n_p1;
        r_p2        <= n_p2;
        r_res_depth <= n_res_depth;
        r_res_outc  <= n_res_outc;
        r_out_depth <= n_out_depth;
        r_out_outc  <= n_out_outc;
    end

    assign o_out_valid = r_out_valid;
    assign o_depth     = r_out_depth;
    assign o_outcome   = r_out_outc;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_LAYERS))
        else $error("layer count beyond store depth");

    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_last_layer) |=> !o_in_ready)
        else $error("input ready right after the closing layer");

    a_overflow_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_outcome == OUTC_OVERFLOW)) |-> (o_depth == '0))
        else $error("overflow result with nonzero depth");

    a_saturated_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_outcome == OUTC_SATURATED)) |-> (o_depth == '0))
        else $error("saturated result with nonzero depth");

endmodule

// ----- hw/rtl/wdf_divider.sv -----
// Restoring divider, one quotient bit per cycle, for the interpolation term.
module wdf_divider import wdf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [QUO_W-1:0] o_quo
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic [DEN_W-1:0]  r_rem, n_rem;
    logic [DEN_W-1:0]  r_den, n_den;
    logic [QUO_W-1:0]  r_lo, n_lo;
    logic [QUO_W-1:0]  r_quo, n_quo;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    always_comb begin
        trial  = {r_rem, r_lo[QUO_W-1]};
        diff   = trial - {1'b0, r_den};
        // The remainder stays below the divisor, so the top bit is a borrow.
        ge     = !diff[DEN_W];
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_lo   = r_lo;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = QCNT_W'(QUO_W - 1);
            n_rem  = DEN_W'(i_num[NUM_W-1:QUO_W]);
            n_lo   = i_num[QUO_W-1:0];
            n_den  = i_den;
        end else if (r_busy) begin
            n_rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            n_lo  = r_lo << 1;
            n_quo = {r_quo[QUO_W-2:0], ge};
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_den <= n_den;
        r_lo  <= n_lo;
        r_quo <= n_quo;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule
